// ===== design/chp_pkg.sv =====
// Shared types and constants for the cartesian-to-polar heading unit.
// No dependencies; the heading unit, chp_prep, chp_sqrt and chp_atan import this package.
package chp_pkg;

  // Tangent table: tan(k deg) for k in 0..44 in unsigned Q52, split into two
  // 26-bit halves so each product stays near a COORD_BITS x 26 multiplier.
  localparam int TanFrac   = 52;
  localparam int TanHalf   = 26;
  localparam int SearchW   = 6;    // bits of the degree search (0..44 in 64)
  localparam int TabDepth  = 64;
  localparam int LastDeg   = 44;
  localparam int AtanLat   = 2 * SearchW + 1;

  localparam logic [8:0] Deg0    = 9'd0;
  localparam logic [8:0] Deg45   = 9'd45;
  localparam logic [8:0] Deg89   = 9'd89;
  localparam logic [8:0] Deg90   = 9'd90;
  localparam logic [8:0] Deg180  = 9'd180;
  localparam logic [8:0] Deg270  = 9'd270;
  localparam logic [9:0] Deg360  = 10'd360;

  localparam logic OpHeading = 1'b0;
  localparam logic OpFacing  = 1'b1;

  localparam real PiR = 3.14159265358979323846;

  typedef logic [TanFrac-1:0] tan_tab_t [TabDepth];

  // Per-item control that rides along the angle search.
  typedef struct packed {
    logic [8:0] base;    // quadrant base angle
    logic       opcode;
    logic       zero;    // coincident points
    logic       swap;    // ratio was inverted, reflect the result
    logic       equal;   // |dx| == |dy|, exactly 45 degrees
  } ang_ctl_t;

  function automatic tan_tab_t tan_table();
    tan_tab_t t;
    real      r;
    for (int k = 0; k < TabDepth; k++) begin
      if (k <= LastDeg) begin
        r    = $tan(real'(k) * PiR / 180.0) * (2.0 ** TanFrac);
        t[k] = TanFrac'(longint'(r));
      end else begin
        t[k] = '1;
      end
    end
    return t;
  endfunction

  localparam tan_tab_t TanQ = tan_table();

endpackage

// ===== design/chp_in_if.sv =====
// Request channel of the heading unit: valid/ready plus the point pair.
// Depends on nothing.
interface chp_in_if #(parameter int COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] from_x;
  logic [COORD_BITS-1:0] from_y;
  logic [COORD_BITS-1:0] to_x;
  logic [COORD_BITS-1:0] to_y;
  logic                  opcode;

  modport source (output valid, from_x, from_y, to_x, to_y, opcode, input ready);
  modport sink   (input valid, from_x, from_y, to_x, to_y, opcode, output ready);
endinterface

// ===== design/chp_out_if.sv =====
// Result channel of the heading unit: valid/ready plus distance and angle.
// Depends on nothing.
interface chp_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] distance;
  logic [8:0]  angle_deg;
  logic        zero_vector;

  modport source (output valid, distance, angle_deg, zero_vector, input ready);
  modport sink   (input valid, distance, angle_deg, zero_vector, output ready);
endinterface

// ===== design/cartesian_to_polar_heading_unit.sv =====
// Path from request to result: one front stage, one for the squares, one for
// their sum and one per root bit, beside the angle search; the shorter path
// is delayed to match. Below 10 coordinate bits the angle search is the longer.
// Throughput: one request per cycle; the whole pipeline stalls as one when
// the output register is full and not taken. Reset clears the valid bits only.
module cartesian_to_polar_heading_unit import chp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  chp_in_if.sink        req_i,
  chp_out_if.source     rsp_o
);

  localparam int SqrtLat = COORD_BITS + 3;
  localparam int MaxLat  = (SqrtLat > AtanLat) ? SqrtLat : AtanLat;
  localparam int DAng    = MaxLat - AtanLat;
  localparam int DDst    = MaxLat - SqrtLat;
  localparam int Total   = MaxLat + 1;   // front stage plus units

  logic                  en;
  logic [Total-1:0]      vld_q;
  logic [COORD_BITS-1:0] ax, ay, num, den;
  ang_ctl_t              ctl;
  logic [COORD_BITS:0]   root;
  logic [8:0]            angle;
  logic                  zero;

  // Advance everything unless a finished result is waiting and not taken.
  assign en          = !vld_q[Total-1] || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Total-2:0], req_i.valid};
    end
  end

  chp_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk_i, .en_i(en),
    .from_x_i(req_i.from_x), .from_y_i(req_i.from_y),
    .to_x_i(req_i.to_x), .to_y_i(req_i.to_y), .opcode_i(req_i.opcode),
    .ax_o(ax), .ay_o(ay), .num_o(num), .den_o(den), .ctl_o(ctl)
  );

  chp_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
    .clk_i, .en_i(en), .ax_i(ax), .ay_i(ay), .root_o(root)
  );

  chp_atan #(.COORD_BITS(COORD_BITS)) u_atan (
    .clk_i, .en_i(en), .num_i(num), .den_i(den), .ctl_i(ctl),
    .angle_o(angle), .zero_o(zero)
  );

  // Hold the shorter path back so both halves of a result meet.
  logic [8:0]  ang_out;
  logic        zero_out;
  logic [16:0] dst_out;

  if (DAng > 0) begin : g_ang_dly
    logic [8:0] a_q [DAng];
    logic       z_q [DAng];
    always_ff @(posedge clk_i) begin
      if (en) begin
        a_q[0] <= angle;
        z_q[0] <= zero;
        for (int i = 1; i < DAng; i++) begin
          a_q[i] <= a_q[i-1];
          z_q[i] <= z_q[i-1];
        end
      end
    end
    assign ang_out  = a_q[DAng-1];
    assign zero_out = z_q[DAng-1];
  end else begin : g_ang_dir
    assign ang_out  = angle;
    assign zero_out = zero;
  end

  if (DDst > 0) begin : g_dst_dly
    logic [16:0] d_q [DDst];
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_q[0] <= 17'(root);
        for (int i = 1; i < DDst; i++) d_q[i] <= d_q[i-1];
      end
    end
    assign dst_out = d_q[DDst-1];
  end else begin : g_dst_dir
    assign dst_out = 17'(root);
  end

  assign rsp_o.valid       = vld_q[Total-1];
  assign rsp_o.distance    = dst_out;
  assign rsp_o.angle_deg   = ang_out;
  assign rsp_o.zero_vector = zero_out;

endmodule

// ===== design/chp_prep.sv =====
// Front stage: differences, magnitudes, quadrant and search operands.
// Depends on chp_pkg.
module chp_prep import chp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [COORD_BITS-1:0] from_x_i,
  input  logic [COORD_BITS-1:0] from_y_i,
  input  logic [COORD_BITS-1:0] to_x_i,
  input  logic [COORD_BITS-1:0] to_y_i,
  input  logic                  opcode_i,
  output logic [COORD_BITS-1:0] ax_o,
  output logic [COORD_BITS-1:0] ay_o,
  output logic [COORD_BITS-1:0] num_o,
  output logic [COORD_BITS-1:0] den_o,
  output ang_ctl_t              ctl_o
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0]   dx, dy;
  logic [COORD_BITS-1:0]  ax, ay, u, v;
  logic                   xpos, xneg, ypos, yneg;
  ang_ctl_t               ctl_d;
  logic [COORD_BITS-1:0]  ax_q, ay_q, num_q, den_q;
  ang_ctl_t               ctl_q;

  always_comb begin
    dx   = signed'({1'b0, to_x_i}) - signed'({1'b0, from_x_i});
    dy   = signed'({1'b0, to_y_i}) - signed'({1'b0, from_y_i});
    ax   = dx[DW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay   = dy[DW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    xneg = dx[DW-1];
    yneg = dy[DW-1];
    xpos = !xneg && (dx != '0);
    ypos = !yneg && (dy != '0);
    ctl_d = '0;
    ctl_d.opcode = opcode_i;
    ctl_d.zero   = (dx == '0) && (dy == '0);
    // Turn the vector by a multiple of 90 deg into the first quadrant.
    if (xpos && !yneg) begin
      ctl_d.base = Deg0;   u = ax; v = ay;
    end else if (!xpos && ypos) begin
      ctl_d.base = Deg90;  u = ay; v = ax;
    end else if (xneg && !ypos) begin
      ctl_d.base = Deg180; u = ax; v = ay;
    end else begin
      ctl_d.base = Deg270; u = ay; v = ax;
    end
    if (ctl_d.zero) ctl_d.base = Deg0;
    ctl_d.equal = (u == v) && !ctl_d.zero;
    ctl_d.swap  = v > u;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q  <= ax;
      ay_q  <= ay;
      num_q <= ctl_d.swap ? u : v;
      den_q <= ctl_d.swap ? v : u;
      ctl_q <= ctl_d;
    end
  end

  assign ax_o  = ax_q;
  assign ay_o  = ay_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign ctl_o = ctl_q;

endmodule

// ===== design/chp_sqrt.sv =====
// Pipelined floor(sqrt(ax^2 + ay^2)): squares, sum, one root bit per stage.
// Depends on chp_pkg.
module chp_sqrt import chp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [COORD_BITS-1:0] ax_i,
  input  logic [COORD_BITS-1:0] ay_i,
  output logic [COORD_BITS:0]   root_o
);

  localparam int M  = COORD_BITS;
  localparam int R  = M + 1;       // root bits
  localparam int W  = 2 * M + 3;   // remainder / trial width

  logic [2*M-1:0] sqx_q, sqy_q;
  logic [W-1:0]   rem_q  [R+1];
  logic [R-1:0]   root_q [R+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q     <= ax_i * ax_i;
      sqy_q     <= ay_i * ay_i;
      rem_q[0]  <= W'(sqx_q) + W'(sqy_q);
      root_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < R; i++) begin : g_bit
    localparam int B = R - 1 - i;
    logic [W-1:0] trial;
    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = (W'(root_q[i]) << (B + 1)) + (W'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial <= rem_q[i]) begin
          rem_q[i+1]  <= rem_q[i] - trial;
          root_q[i+1] <= root_q[i] | (R'(1) << B);
        end else begin
          rem_q[i+1]  <= rem_q[i];
          root_q[i+1] <= root_q[i];
        end
      end
    end
  end

  assign root_o = root_q[R];

endmodule

// ===== design/chp_atan.sv =====
// Pipelined degree search: binary search of the tangent table, one bit per
// two stages (multiply, then compare), then the quadrant and opcode fix-up.
// Depends on chp_pkg.
module chp_atan import chp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [COORD_BITS-1:0] num_i,
  input  logic [COORD_BITS-1:0] den_i,
  input  ang_ctl_t              ctl_i,
  output logic [8:0]            angle_o,
  output logic                  zero_o
);

  localparam int M  = COORD_BITS;
  localparam int PW = M + TanHalf;
  localparam int LW = M + TanFrac + 1;

  logic [M-1:0]       num_q  [SearchW+1];
  logic [M-1:0]       den_q  [SearchW+1];
  ang_ctl_t           ctl_q  [SearchW+1];
  logic [SearchW-1:0] k_q    [SearchW+1];

  logic [M-1:0]       mnum_q [SearchW];
  logic [M-1:0]       mden_q [SearchW];
  ang_ctl_t           mctl_q [SearchW];
  logic [SearchW-1:0] mk_q   [SearchW];
  logic [SearchW-1:0] cand_q [SearchW];
  logic [PW-1:0]      ph_q   [SearchW];
  logic [PW-1:0]      pl_q   [SearchW];

  logic [8:0] angle_q;
  logic       zero_q;

  assign num_q[0] = num_i;
  assign den_q[0] = den_i;
  assign ctl_q[0] = ctl_i;
  assign k_q[0]   = '0;

  for (genvar j = 0; j < SearchW; j++) begin : g_step
    localparam int B = SearchW - 1 - j;
    logic [SearchW-1:0] cand;
    logic [TanFrac-1:0] tv;
    logic [LW-1:0]      lhs, rhs;

    assign cand = k_q[j] | (SearchW'(1) << B);
    assign tv   = TanQ[cand];
    assign lhs  = (LW'(ph_q[j]) << TanHalf) + LW'(pl_q[j]);
    assign rhs  = LW'(mnum_q[j]) << TanFrac;

    // Multiply stage: den * tan(cand), in two halves.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ph_q[j]   <= PW'(den_q[j]) * PW'(tv[TanFrac-1:TanHalf]);
        pl_q[j]   <= PW'(den_q[j]) * PW'(tv[TanHalf-1:0]);
        cand_q[j] <= cand;
        mnum_q[j] <= num_q[j];
        mden_q[j] <= den_q[j];
        mctl_q[j] <= ctl_q[j];
        mk_q[j]   <= k_q[j];
      end
    end

    // Compare stage: keep the candidate when tan(cand) <= num / den.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        k_q[j+1]   <= (lhs <= rhs) ? cand_q[j] : mk_q[j];
        num_q[j+1] <= mnum_q[j];
        den_q[j+1] <= mden_q[j];
        ctl_q[j+1] <= mctl_q[j];
      end
    end
  end

  logic [8:0] q, extra;
  logic [9:0] sum;
  ang_ctl_t   fc;

  always_comb begin
    fc = ctl_q[SearchW];
    if (fc.zero)       q = Deg0;
    else if (fc.equal) q = Deg45;
    else if (fc.swap)  q = Deg89 - 9'(k_q[SearchW]);
    else               q = 9'(k_q[SearchW]);
    extra = (fc.opcode == OpFacing) ? Deg90 : Deg0;
    sum   = 10'(fc.base) + 10'(q) + 10'(extra);
    if (sum >= Deg360) sum = sum - Deg360;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= sum[8:0];
      zero_q  <= fc.zero;
    end
  end

  assign angle_o = angle_q;
  assign zero_o  = zero_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for cartesian_to_polar_heading_unit: directed point pairs, then random ones.
// Depends on chp_pkg and the chp_in_if / chp_out_if interfaces of the design.
module tb import chp_pkg::*; ();

  localparam int NumRandom  = 1530;
  localparam int QuietTail  = 200;
  localparam int CycleLimit = 400000;
  localparam int Iters      = 62;

  typedef struct {
    logic [16:0] distance;
    logic [8:0]  angle_deg;
    logic        zero_vector;
  } polar_t;

  typedef struct {
    logic [15:0] fx, fy, tx, ty;
    logic        op;
    bit          fixed;   // the expected result is typed in below
    polar_t      want;
  } probe_t;

  logic clk_i;
  logic rst_ni;
  chp_in_if #(.COORD_BITS(16)) req_if ();
  chp_out_if                   rsp_if ();

  cartesian_to_polar_heading_unit #(.COORD_BITS(16)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  polar_t   pending_polar[$];
  int       mismatches;
  int       cycles;
  bit       quiet;
  longint   step_q60[Iters];
  longint   pi_q60;

  // Directed requests: coincident points, axis extremes, diagonals, every quadrant.
  probe_t probes[20] = '{
    '{16'd0,     16'd0,     16'd0,     16'd0,     OpHeading, 1, '{17'd0,     9'd0,   1'b1}},
    '{16'd65535, 16'd65535, 16'd65535, 16'd65535, OpFacing,  1, '{17'd0,     9'd90,  1'b1}},
    '{16'd0,     16'd0,     16'd65535, 16'd0,     OpHeading, 1, '{17'd65535, 9'd0,   1'b0}},
    '{16'd65535, 16'd0,     16'd0,     16'd0,     OpHeading, 1, '{17'd65535, 9'd180, 1'b0}},
    '{16'd0,     16'd0,     16'd0,     16'd65535, OpFacing,  1, '{17'd65535, 9'd180, 1'b0}},
    '{16'd0,     16'd65535, 16'd0,     16'd0,     OpHeading, 1, '{17'd65535, 9'd270, 1'b0}},
    '{16'd0,     16'd65535, 16'd0,     16'd0,     OpFacing,  1, '{17'd65535, 9'd0,   1'b0}},
    '{16'd100,   16'd100,   16'd99,    16'd99,    OpHeading, 1, '{17'd1,     9'd225, 1'b0}},
    '{16'd0,     16'd0,     16'd1,     16'd0,     OpFacing,  1, '{17'd1,     9'd90,  1'b0}},
    '{16'd0,     16'd0,     16'd65535, 16'd65535, OpHeading, 0, '{17'd0,     9'd0,   1'b0}},
    '{16'd65535, 16'd65535, 16'd0,     16'd0,     OpFacing,  0, '{17'd0,     9'd0,   1'b0}},
    '{16'd0,     16'd0,     16'd3,     16'd4,     OpHeading, 0, '{17'd0,     9'd0,   1'b0}},
    '{16'd0,     16'd0,     16'd65535, 16'd1,     OpHeading, 0, '{17'd0,     9'd0,   1'b0}},
    '{16'd0,     16'd0,     16'd1,     16'd65535, OpHeading, 0, '{17'd0,     9'd0,   1'b0}},
    '{16'd65535, 16'd0,     16'd0,     16'd65535, OpHeading, 0, '{17'd0,     9'd0,   1'b0}},
    '{16'd1,     16'd0,     16'd0,     16'd65535, OpFacing,  0, '{17'd0,     9'd0,   1'b0}},
    '{16'd0,     16'd65535, 16'd65535, 16'd0,     OpHeading, 0, '{17'd0,     9'd0,   1'b0}},
    '{16'd0,     16'd65535, 16'd65535, 16'd0,     OpFacing,  0, '{17'd0,     9'd0,   1'b0}},
    '{16'd65535, 16'd1,     16'd0,     16'd0,     OpHeading, 0, '{17'd0,     9'd0,   1'b0}},
    '{16'd21845, 16'd43690, 16'd43690, 16'd21845, OpFacing,  0, '{17'd0,     9'd0,   1'b0}}
  };

  // arctan(1/m) in Q60 from its power series, every term truncated
  function automatic longint atan_recip_q60(longint unsigned m);
    longint unsigned t, msq, n;
    longint          s, term;
    t = (64'd1 << 60) / m;
    msq = m * m;
    n = 0;
    s = 0;
    while (t != 0) begin
      term = longint'(t / (2 * n + 1));
      s += n[0] ? -term : term;
      t /= msq;
      n++;
    end
    return s;
  endfunction

  function automatic longint atan_pow2_q60(int i);
    longint s, term;
    int     e, n;
    s = 0;
    n = 0;
    if (i == 0) return pi_q60 / 4;
    for (e = 60 - i; e >= 0; e -= 2 * i) begin
      term = (64'sd1 <<< e) / (2 * n + 1);
      s += n[0] ? -term : term;
      n++;
    end
    return s;
  endfunction

  function automatic longint shr_trunc(longint v, int i);
    return (v >= 0) ? (v >>> i) : -((-v) >>> i);
  endfunction

  // Whole degrees within one quadrant for u > 0, v >= 0, by CORDIC vectoring.
  function automatic int quadrant_deg(longint unsigned u, longint unsigned v);
    longint unsigned big, k;
    longint          x, y, z, xs, ys;
    z = 0;
    if (v == 0) return 0;
    if (u == v) return 45;
    big = (u > v) ? u : v;
    while (big < (64'd1 << 58)) begin
      u <<= 1;
      v <<= 1;
      big <<= 1;
    end
    x = longint'(u);
    y = longint'(v);
    for (int i = 0; i < Iters; i++) begin
      xs = shr_trunc(x, i);
      ys = shr_trunc(y, i);
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += step_q60[i];
      end else begin
        x -= ys;
        y += xs;
        z -= step_q60[i];
      end
    end
    if (z <= 0) return 0;
    k = longint'(z) / longint'(pi_q60 / 180);
    return (k > 89) ? 89 : int'(k);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned sq);
    longint unsigned r, c;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= sq) r = c;
    end
    return r;
  endfunction

  function automatic polar_t polar_of(logic [15:0] fx, fy, tx, ty, logic op);
    polar_t          p;
    longint          dx, dy;
    longint unsigned ax, ay;
    int              base;
    dx = longint'(tx) - longint'(fx);
    dy = longint'(ty) - longint'(fy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    p.zero_vector = (dx == 0 && dy == 0);
    if (p.zero_vector)           base = 0;
    else if (dx > 0 && dy >= 0)  base = quadrant_deg(ax, ay);
    else if (dx <= 0 && dy > 0)  base = 90 + quadrant_deg(ay, ax);
    else if (dx < 0 && dy <= 0)  base = 180 + quadrant_deg(ax, ay);
    else                         base = 270 + quadrant_deg(ay, ax);
    if (op == OpFacing) base += 90;
    p.angle_deg = 9'(base % 360);
    p.distance  = 17'(root_floor(ax * ax + ay * ay));
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Drive one request at the falling edge, hold it until taken, then queue its expected result.
  task automatic send_request(logic [15:0] fx, fy, tx, ty, logic op, polar_t want);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.from_x <= fx;
    req_if.from_y <= fy;
    req_if.to_x   <= tx;
    req_if.to_y   <= ty;
    req_if.opcode <= op;
    do @(posedge clk_i); while (!req_if.ready);
    pending_polar.push_back(want);
    @(negedge clk_i);
  endtask

  // Pick random points, mostly with a delta of a given reach around a random origin, else two random points.
  task automatic send_random();
    logic [15:0] fx, fy, tx, ty;
    logic        op;
    int          kind, span, ddx, ddy;
    fx = 16'($urandom);
    fy = 16'($urandom);
    op = 1'($urandom);
    kind = $urandom_range(0, 9);
    span = (kind < 3) ? 8 : (kind < 5) ? 300 : 65535;
    ddx = int'($urandom_range(0, 2 * span)) - span;
    ddy = int'($urandom_range(0, 2 * span)) - span;
    case (kind)
      5: ddy = 0;                                   // along the x axis
      6: ddx = 0;                                   // along the y axis
      7: ddy = $urandom_range(0, 1) ? ddx : -ddx;   // diagonal, exactly 45
      8: begin ddx = 0; ddy = 0; end                // coincident points
      default: ;
    endcase
    if (kind == 9) begin
      tx = 16'($urandom);
      ty = 16'($urandom);
    end else begin
      // clamp into range by folding the origin back
      if (int'(fx) + ddx > 65535 || int'(fx) + ddx < 0) fx = 16'(int'(fx) - 2 * ddx);
      if (int'(fy) + ddy > 65535 || int'(fy) + ddy < 0) fy = 16'(int'(fy) - 2 * ddy);
      if (int'(fx) + ddx > 65535 || int'(fx) + ddx < 0) fx = (ddx < 0) ? 16'(-ddx) : 16'd0;
      if (int'(fy) + ddy > 65535 || int'(fy) + ddy < 0) fy = (ddy < 0) ? 16'(-ddy) : 16'd0;
      tx = 16'(int'(fx) + ddx);
      ty = 16'(int'(fy) + ddy);
    end
    send_request(fx, fy, tx, ty, op, polar_of(fx, fy, tx, ty, op));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles and abort a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result checker: compare each taken response with the oldest pending one.
  always @(posedge clk_i) begin
    polar_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_polar.size() == 0) begin
        report_mismatch("response with nothing pending", 1, 0);
      end else begin
        want = pending_polar.pop_front();
        if (rsp_if.distance !== want.distance)
          report_mismatch("distance", rsp_if.distance, want.distance);
        if (rsp_if.angle_deg !== want.angle_deg)
          report_mismatch("angle_deg", rsp_if.angle_deg, want.angle_deg);
        if (rsp_if.zero_vector !== want.zero_vector)
          report_mismatch("zero_vector", rsp_if.zero_vector, want.zero_vector);
      end
    end
  end

  // Response backpressure: random stall bursts, none in the tail.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    int drain;
    mismatches    = 0;
    cycles        = 0;
    quiet         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.from_x = '0;
    req_if.from_y = '0;
    req_if.to_x   = '0;
    req_if.to_y   = '0;
    req_if.opcode = OpHeading;
    rst_ni        = 1'b0;

    pi_q60 = 16 * atan_recip_q60(5) - 4 * atan_recip_q60(239);
    for (int i = 0; i < Iters; i++) step_q60[i] = atan_pow2_q60(i);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (probes[i]) begin
      send_request(probes[i].fx, probes[i].fy, probes[i].tx, probes[i].ty, probes[i].op,
                   probes[i].fixed ? probes[i].want
                   : polar_of(probes[i].fx, probes[i].fy, probes[i].tx, probes[i].ty,
                              probes[i].op));
    end

    // Hold the sender until the pipeline has fully drained once.
    req_if.valid <= 1'b0;
    while (pending_polar.size() != 0) @(negedge clk_i);

    for (int n = 0; n < NumRandom; n++) begin
      if (n >= NumRandom - QuietTail) quiet = 1'b1;
      send_random();
    end
    req_if.valid <= 1'b0;

    while (pending_polar.size() != 0) @(negedge clk_i);
    drain = 0;
    while (drain < 40) begin
      @(negedge clk_i);
      drain++;
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
